### design/sitoa_pkg.sv
// Shared constants and types for the signed integer to decimal ASCII block.
// No dependencies; used by every file in design/.
package sitoa_pkg;

   localparam int VALUE_BITS = 32;
   localparam int MAX_DIGITS = 10;

   localparam int BCD_BITS  = 4 * MAX_DIGITS;
   localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);
   localparam int DIG_CNT_W = $clog2(MAX_DIGITS + 1);

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_TRIM,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic skip;
      logic emit;
   } ctrl_type;

endpackage

### design/signed_int_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII text, one character per result.
// Depends on sitoa_pkg and sitoa_dabble.
//
// Usage:
//   Input: drive req_value and raise start; the item is taken at a rising
//   edge where start is high and busy is low. busy stays high until the
//   last character of that item has been put out.
//   Output: each character appears on rsp_char_code / rsp_last_char for a
//   single cycle with rsp_valid high. rsp_last_char marks the final
//   character. The receiver cannot stall; it must take every strobe.
//   A negative value gives '-' on the cycle after acceptance, while the
//   conversion runs.
// Flow:
//   The magnitude goes through the shift-and-add-3 unit once per bit. A scan
//   then drops leading zero digits one per cycle and emits one digit per
//   cycle. A new item is not taken while busy is high, so the block cannot
//   take a new item before the last character of the current one is out.
// Reset: synchronous, active high; the block returns to idle with no
//   strobe pending.
module signed_int_to_decimal_ascii (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [sitoa_pkg::VALUE_BITS-1:0] req_value,
   output logic                                 rsp_valid,
   output logic [7:0]                           rsp_char_code,
   output logic                                 rsp_last_char
);

   localparam int VB = sitoa_pkg::VALUE_BITS;
   localparam int BB = sitoa_pkg::BCD_BITS;
   localparam int BW = sitoa_pkg::BIT_CNT_W;
   localparam int DW = sitoa_pkg::DIG_CNT_W;

   sitoa_pkg::state_type state_ff, state_in;
   sitoa_pkg::ctrl_type  ctrl;

   logic [VB-1:0] mag_ff;
   logic [BB-1:0] bcd_ff;
   logic [BW-1:0] bit_cnt_ff;
   logic [DW-1:0] dig_cnt_ff;
   logic          ovf_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_char_ff, rsp_char_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [VB-1:0] raw_u;
   logic          neg_in;
   logic [VB-1:0] mag_in;
   logic [BB-1:0] bcd_step;
   logic          carry;
   logic          can_skip;
   logic          last_digit;
   logic [3:0]    top_digit;

   assign raw_u  = VB'(req_value);
   assign neg_in = raw_u[VB-1];
   assign mag_in = neg_in ? (~raw_u + {{(VB-1){1'b0}}, 1'b1}) : raw_u;

   sitoa_dabble u_dabble (
      .bcd      (bcd_ff),
      .bin_bit  (mag_ff[VB-1]),
      .bcd_next (bcd_step),
      .carry    (carry)
   );

   assign top_digit  = bcd_ff[BB-1 -: 4];
   assign last_digit = (dig_cnt_ff == DW'(1));
   // leading zeros go unless they are the last digit or high digits were lost
   assign can_skip   = (top_digit == 4'd0) && !last_digit && !ovf_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sitoa_pkg::ST_IDLE: begin
            if (start) state_in = sitoa_pkg::ST_CONV;
         end
         sitoa_pkg::ST_CONV: begin
            if (bit_cnt_ff == BW'(1)) state_in = sitoa_pkg::ST_TRIM;
         end
         sitoa_pkg::ST_TRIM: begin
            if (!can_skip) state_in = sitoa_pkg::ST_EMIT;
         end
         sitoa_pkg::ST_EMIT: begin
            if (last_digit) state_in = sitoa_pkg::ST_IDLE;
         end
         default: state_in = sitoa_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         sitoa_pkg::ST_IDLE: ctrl.load = start;
         sitoa_pkg::ST_CONV: ctrl.step = 1'b1;
         sitoa_pkg::ST_TRIM: ctrl.skip = can_skip;
         sitoa_pkg::ST_EMIT: ctrl.emit = 1'b1;
         default: ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sitoa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         mag_ff     <= mag_in;
         bcd_ff     <= '0;
         bit_cnt_ff <= BW'(VB);
         dig_cnt_ff <= DW'(sitoa_pkg::MAX_DIGITS);
         ovf_ff     <= 1'b0;
      end else if (ctrl.step) begin
         mag_ff     <= {mag_ff[VB-2:0], 1'b0};
         bcd_ff     <= bcd_step;
         bit_cnt_ff <= bit_cnt_ff - BW'(1);
         ovf_ff     <= ovf_ff | carry;
      end else if (ctrl.skip || ctrl.emit) begin
         bcd_ff     <= {bcd_ff[BB-5:0], 4'd0};
         dig_cnt_ff <= dig_cnt_ff - DW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = (ctrl.load && neg_in) || ctrl.emit;
      rsp_char_in  = ctrl.load ? sitoa_pkg::ASCII_MINUS
                               : sitoa_pkg::ASCII_ZERO + {4'd0, top_digit};
      rsp_last_in  = ctrl.emit && last_digit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy          = (state_ff != sitoa_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

endmodule

### design/sitoa_dabble.sv
// One shift-and-add-3 step of the binary to BCD converter.
// Depends on sitoa_pkg for the BCD register width.
module sitoa_dabble (
   input  logic [sitoa_pkg::BCD_BITS-1:0] bcd,
   input  logic                           bin_bit,
   output logic [sitoa_pkg::BCD_BITS-1:0] bcd_next,
   output logic                           carry
);

   logic [sitoa_pkg::BCD_BITS-1:0] adj;

   always_comb begin
      for (int i = 0; i < sitoa_pkg::MAX_DIGITS; i++) begin
         if (bcd[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd[4*i +: 4];
         end
      end
   end

   // bit shifted out of the top digit is a multiple of 10^MAX_DIGITS
   assign carry    = adj[sitoa_pkg::BCD_BITS-1];
   assign bcd_next = {adj[sitoa_pkg::BCD_BITS-2:0], bin_bit};

endmodule

### design/sitoa_checker.sv
// Port-level checks for signed_int_to_decimal_ascii, bound to the top level.
// Depends on sitoa_pkg for the character codes.
module sitoa_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic                                  rsp_valid,
   input logic [7:0]                            rsp_char_code,
   input logic                                  rsp_last_char
);

   logic is_digit;
   assign is_digit = (rsp_char_code >= sitoa_pkg::ASCII_ZERO) &&
                     (rsp_char_code <= sitoa_pkg::ASCII_ZERO + 8'd9);

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (is_digit || rsp_char_code == sitoa_pkg::ASCII_MINUS))
      else $error("character outside '-' and '0'..'9'");

   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_char_code == sitoa_pkg::ASCII_MINUS) |-> !rsp_last_char)
      else $error("minus sign flagged as last character");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after item accepted");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_char) |-> !busy)
      else $error("still busy while last character shown");

   a_no_stray_output: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (!rsp_valid || rsp_last_char))
      else $error("character strobed while idle");

endmodule

bind signed_int_to_decimal_ascii sitoa_checker u_sitoa_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_char_code (rsp_char_code),
   .rsp_last_char (rsp_last_char)
);

### tb/signed_int_to_decimal_ascii_tb.sv
// Testbench for signed_int_to_decimal_ascii: directed table, then random integers with idle gaps.
// Every character is checked against typed text or a decimal text predictor built into this file.
// Depends on sitoa_pkg and the signed_int_to_decimal_ascii RTL.
module signed_int_to_decimal_ascii_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VB            = sitoa_pkg::VALUE_BITS;
   localparam int DIRECTED_ROWS = 18;
   localparam int RANDOM_ITEMS  = 480;
   localparam int CYCLE_LIMIT   = 500000;

   typedef struct {
      logic [7:0] char_code;
      logic       last_char;
   } text_char_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic signed [VB-1:0]          req_value;
   logic                          rsp_valid;
   logic [7:0]                    rsp_char_code;
   logic                          rsp_last_char;

   text_char_type expected_text[$];
   string         row_text_q[$];
   int            fail_count  = 0;
   int            cycle_count = 0;

   // Text is typed in where it is plain from the value; empty means use the predictor.
   logic signed [VB-1:0] dir_value [DIRECTED_ROWS] = '{
      0, 1, -1, 9, 10, -10,
      32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001,
      1000000000, 999999999, -999999999,
      100, -5, 12345, -678901, 32'sh55555555, 32'shAAAAAAAA
   };
   string dir_text [DIRECTED_ROWS] = '{
      "0", "1", "-1", "9", "10", "-10",
      "2147483647", "-2147483648", "-2147483647",
      "1000000000", "999999999", "-999999999",
      "", "-5", "", "", "", ""
   };

   signed_int_to_decimal_ascii dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void queue_typed_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         expected_text.push_back('{text[i], (i == text.len() - 1)});
      end
   endfunction

   // Minus sign first, then digits most significant first; magnitude taken unsigned.
   function automatic void predict_decimal_text(input logic [VB-1:0] value);
      logic [VB-1:0] magnitude;
      logic [3:0]    digit_buf [sitoa_pkg::MAX_DIGITS];
      int            num_digits;
      magnitude  = value[VB-1] ? (~value + 1'b1) : value;
      num_digits = 0;
      if (value[VB-1]) begin
         expected_text.push_back('{sitoa_pkg::ASCII_MINUS, 1'b0});
      end
      if (magnitude == '0) begin
         expected_text.push_back('{sitoa_pkg::ASCII_ZERO, 1'b1});
      end else begin
         while (magnitude != '0 && num_digits < sitoa_pkg::MAX_DIGITS) begin
            digit_buf[num_digits] = 4'(magnitude % 10);
            magnitude             = magnitude / 10;
            num_digits++;
         end
         for (int j = num_digits - 1; j >= 0; j--) begin
            expected_text.push_back('{sitoa_pkg::ASCII_ZERO + 8'(digit_buf[j]), (j == 0)});
         end
      end
   endfunction

   // Mix of full-range words, small numbers and neighbors of powers of ten.
   function automatic logic [VB-1:0] random_value();
      longint mag;
      longint pow10;
      int     sel;
      int     k;
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
         return VB'($urandom);
      end
      if (sel < 7) begin
         mag = $urandom_range(0, 999);
      end else begin
         k     = $urandom_range(0, 9);
         pow10 = 1;
         repeat (k) pow10 *= 10;
         mag = pow10 + longint'($urandom_range(0, 2)) - 1;
      end
      if ($urandom_range(0, 1) == 1) begin
         mag = -mag;
      end
      return mag[VB-1:0];
   endfunction

   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) return 0;
      if (sel < 85) return $urandom_range(1, 3);
      if (sel < 97) return $urandom_range(4, 20);
      return $urandom_range(40, 120);
   endfunction

   task automatic send_item(input logic [VB-1:0] value, input string text,
                            input int gap);
      row_text_q.push_back(text);
      req_value <= value;
      start     <= 1'b1;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start     <= 1'b0;
         req_value <= VB'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Accepted items turn into expected characters; each strobe is checked against the oldest.
   always @(posedge clock) begin
      text_char_type exp_char;
      string         text;
      if (!reset) begin
         if (start && !busy) begin
            text = (row_text_q.size() > 0) ? row_text_q.pop_front() : "";
            if (text.len() > 0) queue_typed_text(text);
            else predict_decimal_text(req_value);
         end
         if (rsp_valid) begin
            if (expected_text.size() == 0) begin
               $error("unexpected character: rsp_char_code %0h rsp_last_char %0b",
                      rsp_char_code, rsp_last_char);
               fail_count++;
            end else begin
               exp_char = expected_text.pop_front();
               if (rsp_char_code !== exp_char.char_code) begin
                  $error("rsp_char_code: expected %0h, got %0h",
                         exp_char.char_code, rsp_char_code);
                  fail_count++;
               end
               if (rsp_last_char !== exp_char.last_char) begin
                  $error("rsp_last_char: expected %0b, got %0b",
                         exp_char.last_char, rsp_last_char);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int burst_left;
      int gap;
      burst_left = 0;
      reset      = 1'b1;
      start      = 1'b0;
      req_value  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_item(dir_value[i], dir_text[i], (i % 3 == 2) ? 1 : 0);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // occasional back-to-back stretches with no idle cycles at all
         if (burst_left == 0 && $urandom_range(0, 24) == 0) begin
            burst_left = $urandom_range(20, 40);
         end
         if (burst_left > 0) begin
            gap = 0;
            burst_left--;
         end else begin
            gap = pick_gap();
         end
         send_item(random_value(), "", gap);
      end
      start <= 1'b0;

      while (expected_text.size() != 0 || row_text_q.size() != 0) @(posedge clock);
      repeat (VB + sitoa_pkg::MAX_DIGITS + 8) @(posedge clock);

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
